// ----- src/gpt_pkg.sv -----
package gpt_pkg;

   // result kinds on the response channel
   typedef enum logic [1:0] {
      KIND_VERTEX   = 2'd0,
      KIND_TRIANGLE = 2'd1,
      KIND_REJECT   = 2'd2
   } kind_type;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 48;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CORNER_A    = 4'd0,
      REG_CORNER_B    = 4'd1,
      REG_CORNER_C    = 4'd2,
      REG_CORNER_D    = 4'd3,
      REG_FACE_NORMAL = 4'd4,
      REG_WIDTH_SEG   = 4'd5,
      REG_HEIGHT_SEG  = 4'd6,
      REG_CCW         = 4'd7
   } csr_index_type;

   // triangle emission phases after a vertex
   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_FIRST  = 2'd1,
      PHASE_SECOND = 2'd2
   } phase_type;

   // texture coordinate format and divider shape
   localparam int UV_BITS     = 16;
   localparam logic [UV_BITS-1:0] ONE_UV = 16'h8000;
   localparam int QUOT_BITS   = 17;
   localparam int DIV_STEPS   = 3;
   localparam int WEIGHT_BITS = 31;
   localparam int ROUND_SHIFT = 30;
   localparam int INDEX_BITS  = 32;

   // control bits that travel with each pipeline stage
   typedef struct packed {
      logic valid;
      logic reject;
      logic has_tri;
   } ctl_type;

endpackage

// ----- src/grid_plane_tessellator_unit.sv -----
// grid plane tessellator
// One transaction on the request side names a grid point (column, row) and a
// vertex base. It is accepted at a rising edge where start is high and busy
// is low. For each point the block strobes rsp_valid for one cycle with a
// vertex result; points inside the quad range are followed directly by two
// triangle results, and points outside the grid give a single rejected
// result instead.
// The vertex or rejected result is registered through one input stage, a
// six-stage u/v divider, weight, product, partial sum, final round and
// output stages. Triangles follow on the next cycles.
// A point that yields only one result can be followed in the next cycle; a
// point that yields triangles holds busy so that the next point cannot reach
// the single result port while its triangles go out.
// The csr_ port writes a register at any edge where csr_write_enable is high;
// write only while no transaction is in flight.
// Reset (synchronous) empties the pipeline and loads the default corners,
// normal (0, 1.0, 0), one segment each way and counter-clockwise winding.
// The receiver cannot stall: each result is taken in its strobe cycle.
module grid_plane_tessellator_unit
   import gpt_pkg::*;
#(
   parameter int SEGMENT_BITS = 10,
   parameter int COORD_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [SEGMENT_BITS-1:0]        req_column_index,
   input  logic [SEGMENT_BITS-1:0]        req_row_index,
   input  logic [INDEX_BITS-1:0]          req_vertex_base,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_result_kind,
   output logic signed [COORD_BITS-1:0]   rsp_pos_x,
   output logic signed [COORD_BITS-1:0]   rsp_pos_y,
   output logic signed [COORD_BITS-1:0]   rsp_pos_z,
   output logic signed [COORD_BITS-1:0]   rsp_normal_x,
   output logic signed [COORD_BITS-1:0]   rsp_normal_y,
   output logic signed [COORD_BITS-1:0]   rsp_normal_z,
   output logic [UV_BITS-1:0]             rsp_tex_u,
   output logic [UV_BITS-1:0]             rsp_tex_v,
   output logic [INDEX_BITS-1:0]          rsp_tri_first,
   output logic [INDEX_BITS-1:0]          rsp_tri_second,
   output logic [INDEX_BITS-1:0]          rsp_tri_third,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [CSR_DATA_BITS-1:0]       csr_write_data
);

   localparam int REM_BITS   = SEGMENT_BITS + 2;
   localparam int DIV_BITS   = SEGMENT_BITS + 1;
   localparam int NUM_BITS   = SEGMENT_BITS + QUOT_BITS;
   localparam int DIV_STAGES = (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int PROD_BITS  = COORD_BITS + WEIGHT_BITS + 1;
   localparam int PAIR_BITS  = PROD_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 2;
   localparam int RND_BITS   = SUM_BITS - ROUND_SHIFT;
   localparam logic signed [RND_BITS-1:0] POS_MAX =
      RND_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [RND_BITS-1:0] POS_MIN = -POS_MAX - RND_BITS'(1);
   localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(64'd1 << (ROUND_SHIFT - 1));

   typedef struct packed {
      logic [REM_BITS-1:0]  rem;
      logic [QUOT_BITS-1:0] low;
      logic [QUOT_BITS-1:0] quo;
   } div_type;

   // a few restoring division steps, one quotient bit each
   function automatic div_type div_run(input div_type st, input logic [DIV_BITS-1:0] d,
                                       input int count);
      div_type             r;
      logic [REM_BITS-1:0] t;
      r = st;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k < count) begin
            t     = {r.rem[REM_BITS-2:0], r.low[QUOT_BITS-1]};
            r.low = {r.low[QUOT_BITS-2:0], 1'b0};
            if (t >= REM_BITS'(d)) begin
               r.rem = t - REM_BITS'(d);
               r.quo = {r.quo[QUOT_BITS-2:0], 1'b1};
            end else begin
               r.rem = t;
               r.quo = {r.quo[QUOT_BITS-2:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

   // one coordinate lane of a packed x,y,z register
   function automatic logic [COORD_BITS-1:0] lane_of(input logic [CSR_DATA_BITS-1:0] r,
                                                     input int k);
      logic [63:0] wide;
      wide = {16'b0, r};
      if (k * COORD_BITS >= 64) return '0;
      return COORD_BITS'(wide >> (k * COORD_BITS));
   endfunction

   // configuration registers
   logic [CSR_DATA_BITS-1:0] corner_a_ff, corner_b_ff, corner_c_ff, corner_d_ff;
   logic [CSR_DATA_BITS-1:0] normal_ff;
   logic [SEGMENT_BITS-1:0]  width_ff, height_ff;
   logic                     ccw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_a_ff <= '0;
         corner_b_ff <= '0;
         corner_c_ff <= '0;
         corner_d_ff <= '0;
         normal_ff   <= 48'h0000_0100_0000;
         width_ff    <= SEGMENT_BITS'(1);
         height_ff   <= SEGMENT_BITS'(1);
         ccw_ff      <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_CORNER_A:    corner_a_ff <= csr_write_data;
            REG_CORNER_B:    corner_b_ff <= csr_write_data;
            REG_CORNER_C:    corner_c_ff <= csr_write_data;
            REG_CORNER_D:    corner_d_ff <= csr_write_data;
            REG_FACE_NORMAL: normal_ff   <= csr_write_data;
            REG_WIDTH_SEG:   width_ff    <= csr_write_data[SEGMENT_BITS-1:0];
            REG_HEIGHT_SEG:  height_ff   <= csr_write_data[SEGMENT_BITS-1:0];
            REG_CCW:         ccw_ff      <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // effective segment counts, zero counts as one
   logic [SEGMENT_BITS-1:0] w_eff, h_eff;
   logic [DIV_BITS-1:0]     col_step;
   assign w_eff    = (width_ff == '0) ? SEGMENT_BITS'(1) : width_ff;
   assign h_eff    = (height_ff == '0) ? SEGMENT_BITS'(1) : height_ff;
   assign col_step = DIV_BITS'(h_eff) + DIV_BITS'(1);

   // admission: a point with triangles holds busy to block the next requests
   logic       accept, reject_in, tri_in;
   logic [1:0] hold_ff, hold_in;
   assign accept    = start && !busy;
   assign reject_in = (req_column_index > w_eff) || (req_row_index > h_eff);
   assign tri_in    = !reject_in && (req_column_index < w_eff) && (req_row_index < h_eff);
   assign busy      = (hold_ff != 2'd0);

   always_comb begin
      hold_in = hold_ff;
      if (accept && tri_in) hold_in = 2'd2;
      else if (hold_ff != 2'd0) hold_in = hold_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) hold_ff <= 2'd0;
      else hold_ff <= hold_in;
   end

   // input stage
   ctl_type                 a_ctl_ff;
   logic [SEGMENT_BITS-1:0] a_i_ff, a_j_ff;
   logic [INDEX_BITS-1:0]   a_bj_ff;

   always_ff @(posedge clock) begin
      if (reset) a_ctl_ff <= '0;
      else a_ctl_ff <= '{valid: accept, reject: reject_in, has_tri: tri_in};
   end

   always_ff @(posedge clock) begin
      a_i_ff  <= req_column_index;
      a_j_ff  <= req_row_index;
      a_bj_ff <= req_vertex_base + INDEX_BITS'(req_row_index);
   end

   // divider start: round(i*2^15/w) = floor((i*2^16 + w) / 2w)
   logic [NUM_BITS-1:0] num_u, num_v;
   div_type             init_u, init_v;
   logic [DIV_BITS-1:0] den_u, den_v;
   logic [2*SEGMENT_BITS:0] quad_prod;

   always_comb begin
      num_u  = NUM_BITS'({a_i_ff, 16'b0}) + NUM_BITS'(w_eff);
      num_v  = NUM_BITS'({a_j_ff, 16'b0}) + NUM_BITS'(h_eff);
      init_u = '{rem: REM_BITS'(num_u[NUM_BITS-1:QUOT_BITS]),
                 low: num_u[QUOT_BITS-1:0], quo: '0};
      init_v = '{rem: REM_BITS'(num_v[NUM_BITS-1:QUOT_BITS]),
                 low: num_v[QUOT_BITS-1:0], quo: '0};
      den_u  = {w_eff, 1'b0};
      den_v  = {h_eff, 1'b0};
      quad_prod = a_i_ff * col_step;
   end

   // divider pipeline, quad index built alongside
   ctl_type               d_ctl_ff [DIV_STAGES];
   div_type               du_ff    [DIV_STAGES];
   div_type               dv_ff    [DIV_STAGES];
   logic [INDEX_BITS-1:0] d_idx_ff [DIV_STAGES];
   logic [INDEX_BITS-1:0] d_bj_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      localparam int CNT = (QUOT_BITS - g * DIV_STEPS < DIV_STEPS) ?
                           (QUOT_BITS - g * DIV_STEPS) : DIV_STEPS;
      if (g == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) d_ctl_ff[g] <= '0;
            else d_ctl_ff[g] <= a_ctl_ff;
         end
         always_ff @(posedge clock) begin
            du_ff[g]    <= div_run(init_u, den_u, CNT);
            dv_ff[g]    <= div_run(init_v, den_v, CNT);
            d_idx_ff[g] <= INDEX_BITS'(quad_prod);
            d_bj_ff     <= a_bj_ff;
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (reset) d_ctl_ff[g] <= '0;
            else d_ctl_ff[g] <= d_ctl_ff[g-1];
         end
         always_ff @(posedge clock) begin
            du_ff[g]    <= div_run(du_ff[g-1], den_u, CNT);
            dv_ff[g]    <= div_run(dv_ff[g-1], den_v, CNT);
            d_idx_ff[g] <= (g == 1) ? d_idx_ff[g-1] + d_bj_ff : d_idx_ff[g-1];
         end
      end
   end

   // corner weight stage
   logic [UV_BITS-1:0]     u_q, v_q, ou_q, ov_q;
   logic [2*UV_BITS-1:0]   wa_p, wb_p, wc_p, wd_p;
   ctl_type                w_ctl_ff;
   logic [UV_BITS-1:0]     w_u_ff, w_v_ff;
   logic [WEIGHT_BITS-1:0] w_wt_ff [4];
   logic [INDEX_BITS-1:0]  w_idx_ff;

   always_comb begin
      u_q  = du_ff[DIV_STAGES-1].quo[UV_BITS-1:0];
      v_q  = dv_ff[DIV_STAGES-1].quo[UV_BITS-1:0];
      ou_q = ONE_UV - u_q;
      ov_q = ONE_UV - v_q;
      wa_p = {16'b0, ou_q} * {16'b0, ov_q};
      wb_p = {16'b0, u_q}  * {16'b0, ov_q};
      wc_p = {16'b0, ou_q} * {16'b0, v_q};
      wd_p = {16'b0, u_q}  * {16'b0, v_q};
   end

   always_ff @(posedge clock) begin
      if (reset) w_ctl_ff <= '0;
      else w_ctl_ff <= d_ctl_ff[DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      w_u_ff     <= u_q;
      w_v_ff     <= v_q;
      w_wt_ff[0] <= wa_p[WEIGHT_BITS-1:0];
      w_wt_ff[1] <= wb_p[WEIGHT_BITS-1:0];
      w_wt_ff[2] <= wc_p[WEIGHT_BITS-1:0];
      w_wt_ff[3] <= wd_p[WEIGHT_BITS-1:0];
      w_idx_ff   <= d_idx_ff[DIV_STAGES-1];
   end

   // corner times weight, three lanes of four products
   logic signed [COORD_BITS-1:0] corner_lane [3][4];
   logic signed [PROD_BITS-1:0]  prod_in     [3][4];
   ctl_type                      m_ctl_ff;
   logic signed [PROD_BITS-1:0]  m_prod_ff   [3][4];
   logic [UV_BITS-1:0]           m_u_ff, m_v_ff;
   logic [INDEX_BITS-1:0]        m_idx_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         corner_lane[k][0] = $signed(lane_of(corner_a_ff, k));
         corner_lane[k][1] = $signed(lane_of(corner_b_ff, k));
         corner_lane[k][2] = $signed(lane_of(corner_c_ff, k));
         corner_lane[k][3] = $signed(lane_of(corner_d_ff, k));
         for (int c = 0; c < 4; c++) begin
            prod_in[k][c] = corner_lane[k][c] * $signed({1'b0, w_wt_ff[c]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) m_ctl_ff <= '0;
      else m_ctl_ff <= w_ctl_ff;
   end

   always_ff @(posedge clock) begin
      m_prod_ff <= prod_in;
      m_u_ff    <= w_u_ff;
      m_v_ff    <= w_v_ff;
      m_idx_ff  <= w_idx_ff;
   end

   // partial sums and triangle corner indexes
   ctl_type                     s_ctl_ff;
   logic signed [PAIR_BITS-1:0] s_pair_ff [3][2];
   logic [UV_BITS-1:0]          s_u_ff, s_v_ff;
   logic [INDEX_BITS-1:0]       s_q_ff, s_q1_ff, s_qc_ff, s_q1c_ff;

   always_ff @(posedge clock) begin
      if (reset) s_ctl_ff <= '0;
      else s_ctl_ff <= m_ctl_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         s_pair_ff[k][0] <= PAIR_BITS'(m_prod_ff[k][0]) + PAIR_BITS'(m_prod_ff[k][1]);
         s_pair_ff[k][1] <= PAIR_BITS'(m_prod_ff[k][2]) + PAIR_BITS'(m_prod_ff[k][3]);
      end
      s_u_ff   <= m_u_ff;
      s_v_ff   <= m_v_ff;
      s_q_ff   <= m_idx_ff;
      s_q1_ff  <= m_idx_ff + INDEX_BITS'(1);
      s_qc_ff  <= m_idx_ff + INDEX_BITS'(col_step);
      s_q1c_ff <= m_idx_ff + INDEX_BITS'(col_step) + INDEX_BITS'(1);
   end

   // final sum, round half up, clamp
   logic signed [SUM_BITS-1:0]   sum_k    [3];
   logic signed [SUM_BITS-1:0]   biased_k [3];
   logic signed [RND_BITS-1:0]   rnd_k    [3];
   logic signed [COORD_BITS-1:0] pos_in   [3];
   ctl_type                      f_ctl_ff;
   logic signed [COORD_BITS-1:0] f_pos_ff [3];
   logic [UV_BITS-1:0]           f_u_ff, f_v_ff;
   logic [INDEX_BITS-1:0]        f_q_ff, f_q1_ff, f_qc_ff, f_q1c_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_k[k]    = SUM_BITS'(s_pair_ff[k][0]) + SUM_BITS'(s_pair_ff[k][1]);
         biased_k[k] = sum_k[k] + $signed(ROUND_HALF);
         rnd_k[k]    = biased_k[k][SUM_BITS-1:ROUND_SHIFT];
         if (rnd_k[k] > POS_MAX) pos_in[k] = POS_MAX[COORD_BITS-1:0];
         else if (rnd_k[k] < POS_MIN) pos_in[k] = POS_MIN[COORD_BITS-1:0];
         else pos_in[k] = rnd_k[k][COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) f_ctl_ff <= '0;
      else f_ctl_ff <= s_ctl_ff;
   end

   always_ff @(posedge clock) begin
      f_pos_ff <= pos_in;
      f_u_ff   <= s_u_ff;
      f_v_ff   <= s_v_ff;
      f_q_ff   <= s_q_ff;
      f_q1_ff  <= s_q1_ff;
      f_qc_ff  <= s_qc_ff;
      f_q1c_ff <= s_q1c_ff;
   end

   // triangle sequencer: next state
   phase_type             phase_ff, phase_in;
   logic [INDEX_BITS-1:0] t_q_ff, t_q1_ff, t_qc_ff, t_q1c_ff;

   always_comb begin
      phase_in = PHASE_IDLE;
      unique case (phase_ff)
         PHASE_IDLE:   phase_in = (f_ctl_ff.valid && f_ctl_ff.has_tri) ? PHASE_FIRST
                                                                        : PHASE_IDLE;
         PHASE_FIRST:  phase_in = PHASE_SECOND;
         PHASE_SECOND: phase_in = PHASE_IDLE;
         default:      phase_in = PHASE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= PHASE_IDLE;
      else phase_ff <= phase_in;
   end

   always_ff @(posedge clock) begin
      if (f_ctl_ff.valid) begin
         t_q_ff   <= f_q_ff;
         t_q1_ff  <= f_q1_ff;
         t_qc_ff  <= f_qc_ff;
         t_q1c_ff <= f_q1c_ff;
      end
   end

   // triangle sequencer and vertex path: outputs
   logic                         rv_in;
   kind_type                     kind_in;
   logic signed [COORD_BITS-1:0] op_in  [3];
   logic signed [COORD_BITS-1:0] on_in  [3];
   logic [UV_BITS-1:0]           ou_in, ov_in;
   logic [INDEX_BITS-1:0]        ot_in  [3];

   always_comb begin
      rv_in   = 1'b0;
      kind_in = KIND_VERTEX;
      ou_in   = '0;
      ov_in   = '0;
      for (int k = 0; k < 3; k++) begin
         op_in[k] = '0;
         on_in[k] = '0;
         ot_in[k] = '0;
      end
      if (f_ctl_ff.valid) begin
         rv_in = 1'b1;
         if (f_ctl_ff.reject) begin
            kind_in = KIND_REJECT;
         end else begin
            kind_in = KIND_VERTEX;
            ou_in   = f_u_ff;
            ov_in   = f_v_ff;
            for (int k = 0; k < 3; k++) begin
               op_in[k] = f_pos_ff[k];
               on_in[k] = $signed(lane_of(normal_ff, k));
            end
         end
      end else begin
         unique case (phase_ff)
            PHASE_FIRST: begin
               rv_in    = 1'b1;
               kind_in  = KIND_TRIANGLE;
               ot_in[0] = t_q_ff;
               ot_in[1] = ccw_ff ? t_q1_ff : t_qc_ff;
               ot_in[2] = ccw_ff ? t_qc_ff : t_q1_ff;
            end
            PHASE_SECOND: begin
               rv_in    = 1'b1;
               kind_in  = KIND_TRIANGLE;
               ot_in[0] = t_q1_ff;
               ot_in[1] = ccw_ff ? t_q1c_ff : t_qc_ff;
               ot_in[2] = ccw_ff ? t_qc_ff : t_q1c_ff;
            end
            default: ;
         endcase
      end
   end

   // result register
   logic                         rsp_valid_ff;
   kind_type                     rsp_kind_ff;
   logic signed [COORD_BITS-1:0] rsp_pos_ff    [3];
   logic signed [COORD_BITS-1:0] rsp_normal_ff [3];
   logic [UV_BITS-1:0]           rsp_u_ff, rsp_v_ff;
   logic [INDEX_BITS-1:0]        rsp_tri_ff    [3];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rv_in;
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= kind_in;
      rsp_pos_ff    <= op_in;
      rsp_normal_ff <= on_in;
      rsp_u_ff      <= ou_in;
      rsp_v_ff      <= ov_in;
      rsp_tri_ff    <= ot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_pos_x       = rsp_pos_ff[0];
   assign rsp_pos_y       = rsp_pos_ff[1];
   assign rsp_pos_z       = rsp_pos_ff[2];
   assign rsp_normal_x    = rsp_normal_ff[0];
   assign rsp_normal_y    = rsp_normal_ff[1];
   assign rsp_normal_z    = rsp_normal_ff[2];
   assign rsp_tex_u       = rsp_u_ff;
   assign rsp_tex_v       = rsp_v_ff;
   assign rsp_tri_first   = rsp_tri_ff[0];
   assign rsp_tri_second  = rsp_tri_ff[1];
   assign rsp_tri_third   = rsp_tri_ff[2];

   // a finished point never lands while triangles are still going out
   a_no_collision: assert property (@(posedge clock) disable iff (reset)
      f_ctl_ff.valid |-> (phase_ff == PHASE_IDLE))
      else $error("vertex collides with pending triangles");

   // a point with triangles blocks the request side next cycle
   a_hold_after_quad: assert property (@(posedge clock) disable iff (reset)
      (accept && tri_in) |=> busy)
      else $error("busy not raised after a quad point");

   // a triangle always follows another result
   a_tri_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_TRIANGLE) |-> $past(rsp_valid))
      else $error("triangle without a preceding result");

   // a rejected point is never directly followed by a triangle
   a_reject_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_REJECT)
         |=> !(rsp_valid && rsp_result_kind == KIND_TRIANGLE))
      else $error("triangle after a rejected point");

endmodule

// ----- bench/tessellation_checker.sv -----
module tessellation_checker
   import gpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [9:0]                req_column_index,
   input  logic [9:0]                req_row_index,
   input  logic [31:0]               req_vertex_base,
   input  logic                      rsp_valid,
   input  logic [1:0]                rsp_result_kind,
   input  logic [15:0]               rsp_pos_x,
   input  logic [15:0]               rsp_pos_y,
   input  logic [15:0]               rsp_pos_z,
   input  logic [15:0]               rsp_normal_x,
   input  logic [15:0]               rsp_normal_y,
   input  logic [15:0]               rsp_normal_z,
   input  logic [15:0]               rsp_tex_u,
   input  logic [15:0]               rsp_tex_v,
   input  logic [31:0]               rsp_tri_first,
   input  logic [31:0]               rsp_tri_second,
   input  logic [31:0]               rsp_tri_third,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output int                        error_count,
   output int                        pending_count
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] px, py, pz, nx, ny, nz, tu, tv;
      logic [31:0] t0, t1, t2;
   } mesh_result_t;

   mesh_result_t expected_mesh[$];

   // shadow copy of the block registers
   logic [47:0] corner_a, corner_b, corner_c, corner_d, face_normal;
   logic [9:0]  width_segs, height_segs;
   logic        ccw;

   function automatic longint lane_of(logic [47:0] r, int k);
      logic signed [15:0] s;
      s = r[k*16 +: 16];
      return longint'(s);
   endfunction

   function automatic longint tex_ratio(longint n, longint d);
      return (n * 32768 * 2 + d) / (2 * d);
   endfunction

   function automatic logic [15:0] blend_lane(int k, longint u, longint v);
      longint sum, r;
      sum = lane_of(corner_a, k) * ((32768 - u) * (32768 - v))
          + lane_of(corner_b, k) * (u * (32768 - v))
          + lane_of(corner_c, k) * ((32768 - u) * v)
          + lane_of(corner_d, k) * (u * v);
      r = ((sum + (longint'(32768) << 30) + (longint'(1) << 29)) >>> 30) - 32768;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   task automatic tessellate_point(logic [9:0] ci, logic [9:0] rj, logic [31:0] base);
      mesh_result_t m;
      longint w, h, u, v;
      logic [31:0] q, c;
      w = (width_segs == 0) ? 1 : width_segs;
      h = (height_segs == 0) ? 1 : height_segs;
      m = '0;
      if (ci > w || rj > h) begin
         m.kind = KIND_REJECT;
         expected_mesh.insert(expected_mesh.size(), m);
         return;
      end
      u = tex_ratio(ci, w);
      v = tex_ratio(rj, h);
      m.kind = KIND_VERTEX;
      m.px = blend_lane(0, u, v);
      m.py = blend_lane(1, u, v);
      m.pz = blend_lane(2, u, v);
      m.nx = face_normal[15:0];
      m.ny = face_normal[31:16];
      m.nz = face_normal[47:32];
      m.tu = u[15:0];
      m.tv = v[15:0];
      expected_mesh.insert(expected_mesh.size(), m);
      if (ci == w || rj == h) return;
      c = h[31:0] + 32'd1;
      q = base + 32'(ci) * c + 32'(rj);
      m = '0;
      m.kind = KIND_TRIANGLE;
      m.t0 = q;
      if (ccw) begin
         m.t1 = q + 1; m.t2 = q + c;
      end else begin
         m.t1 = q + c; m.t2 = q + 1;
      end
      expected_mesh.insert(expected_mesh.size(), m);
      m.t0 = q + 1;
      if (ccw) begin
         m.t1 = q + 1 + c; m.t2 = q + c;
      end else begin
         m.t1 = q + c; m.t2 = q + 1 + c;
      end
      expected_mesh.insert(expected_mesh.size(), m);
   endtask

   assign pending_count = expected_mesh.size();

   // watch all three channels
   always @(posedge clock) begin
      mesh_result_t got, want;
      if (reset) begin
         corner_a <= '0; corner_b <= '0; corner_c <= '0; corner_d <= '0;
         face_normal <= 48'd16777216;
         width_segs <= 10'd1; height_segs <= 10'd1; ccw <= 1'b1;
         expected_mesh.delete();
         error_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_CORNER_A: corner_a <= csr_write_data;
               REG_CORNER_B: corner_b <= csr_write_data;
               REG_CORNER_C: corner_c <= csr_write_data;
               REG_CORNER_D: corner_d <= csr_write_data;
               REG_FACE_NORMAL: face_normal <= csr_write_data;
               REG_WIDTH_SEG: width_segs <= csr_write_data[9:0];
               REG_HEIGHT_SEG: height_segs <= csr_write_data[9:0];
               REG_CCW: ccw <= csr_write_data[0];
               default: ;
            endcase
         end
         if (start && !busy)
            tessellate_point(req_column_index, req_row_index, req_vertex_base);
         if (rsp_valid) begin
            got = {rsp_result_kind, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_normal_x,
                   rsp_normal_y, rsp_normal_z, rsp_tex_u, rsp_tex_v,
                   rsp_tri_first, rsp_tri_second, rsp_tri_third};
            if (expected_mesh.size() == 0) begin
               if (error_count < 10) $display("unexpected result %h", got);
               error_count <= error_count + 1;
            end else begin
               want = expected_mesh.pop_front();
               if (got !== want) begin
                  if (error_count < 10)
                     $display("mismatch exp %h got %h", want, got);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- bench/tb_grid_plane_tessellator_unit.sv -----
module tb_grid_plane_tessellator_unit;
   import gpt_pkg::*;

   logic clock, reset, start, busy;
   logic [9:0] req_column_index, req_row_index;
   logic [31:0] req_vertex_base;
   logic rsp_valid;
   logic [1:0] rsp_result_kind;
   logic signed [15:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [15:0] rsp_tex_u, rsp_tex_v;
   logic [31:0] rsp_tri_first, rsp_tri_second, rsp_tri_third;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;
   int error_count, pending_count, cycle_count;
   int idle_pct;

   grid_plane_tessellator_unit dut (.*);
   tessellation_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 200000) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // one register write, then write enable goes low again
   task automatic write_reg(csr_index_type idx, logic [47:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // wait out in-flight results before touching registers
   task automatic drain();
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // start stays high after the accept so points can follow back to back
   task automatic send_point(logic [9:0] ci, logic [9:0] rj, logic [31:0] base);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_column_index <= ci;
      req_row_index <= rj;
      req_vertex_base <= base;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic random_setup(bit extreme);
      write_reg(REG_CORNER_A, 48'({$urandom, $urandom}));
      write_reg(REG_CORNER_B, 48'({$urandom, $urandom}));
      write_reg(REG_CORNER_C, extreme ? 48'h7fff7fff7fff : 48'({$urandom, $urandom}));
      write_reg(REG_CORNER_D, extreme ? 48'h800080008000 : 48'({$urandom, $urandom}));
      write_reg(REG_FACE_NORMAL, 48'({$urandom, $urandom}));
      write_reg(REG_WIDTH_SEG, extreme ? 48'd1023 : 48'($urandom_range(0, 12)));
      write_reg(REG_HEIGHT_SEG, extreme ? 48'd1023 : 48'($urandom_range(0, 12)));
      write_reg(REG_CCW, 48'($urandom_range(0, 1)));
      write_reg(csr_index_type'(4'd12), 48'({$urandom, $urandom}));
   endtask

   task automatic random_points(int n, int wmax, int hmax);
      repeat (n) begin
         if ($urandom_range(9) == 0)
            send_point(10'($urandom), 10'($urandom), $urandom);
         else
            send_point(10'($urandom_range(0, wmax)), 10'($urandom_range(0, hmax)),
                       $urandom);
      end
   endtask

   initial begin
      reset = 1; start = 0; csr_write_enable = 0; csr_index = '0;
      csr_write_data = '0; req_column_index = '0; req_row_index = '0;
      req_vertex_base = '0; idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset settings, grid corners, outside points, wrap
      send_point(0, 0, 0);
      send_point(1, 1, 0);
      send_point(1, 0, 32'hffffffff);
      send_point(2, 0, 0);
      send_point(0, 2, 0);
      send_point(10'h3ff, 10'h3ff, 32'hfffffffe);
      drain();
      write_reg(REG_CORNER_A, 48'h800080008000);
      write_reg(REG_CORNER_B, 48'h7fff7fff7fff);
      write_reg(REG_CORNER_C, 48'h7fff7fff7fff);
      write_reg(REG_CORNER_D, 48'h7fff7fff7fff);
      write_reg(REG_FACE_NORMAL, 48'hffffffffffff);
      write_reg(REG_WIDTH_SEG, 48'hfffffffffc00);
      write_reg(REG_HEIGHT_SEG, 48'd3);
      write_reg(REG_CCW, 48'hfffffffffffe);
      send_point(0, 0, 32'hffffffff);
      send_point(1, 3, 5);
      send_point(0, 2, 7);
      send_point(0, 3, 7);
      send_point(1, 1, 0);
      send_point(0, 4, 0);
      drain();
      write_reg(REG_WIDTH_SEG, 48'd1023);
      write_reg(REG_HEIGHT_SEG, 48'd1023);
      write_reg(REG_CCW, 48'd1);
      send_point(1022, 1022, 32'hffffffff);
      send_point(1023, 1023, 0);
      send_point(511, 3, 0);
      drain();
      // random phases with different idling
      for (int ph = 0; ph < 9; ph++) begin
         idle_pct = (ph < 3) ? 26 : (ph < 6 ? 80 : 0);
         random_setup(ph == 4);
         random_points(40, (ph == 4) ? 1023 : 13, (ph == 4) ? 1023 : 13);
         drain();
      end
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
